@@ rtl/core/smema_pkg.sv @@
package smema_pkg;

  localparam int RES_BITS   = 24;
  localparam int WL_W       = 9;
  localparam int ALPHA_W    = 16;
  localparam int EMA_FRAC   = 16;
  localparam int CFG_DW     = 32;
  localparam int CFG_AW     = 3;

  localparam logic [WL_W-1:0]    WL_RESET    = 9'd20;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6242;
  localparam logic [EMA_FRAC-1:0] EMA_BIAS   = 16'hFFFF;

  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_ALPHA  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_SUM,
    S_DIV,
    S_MLO,
    S_MHI,
    S_UPD,
    S_OUT
  } state_t;

endpackage

@@ rtl/core/smema_if.sv @@
interface smema_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   first_of_series;

  modport source (output valid, output sample, output first_of_series, input ready);
  modport sink   (input valid, input sample, input first_of_series, output ready);
endinterface

interface smema_out_if;
  logic                           valid;
  logic                           ready;
  logic [smema_pkg::RES_BITS-1:0] sma;
  logic [smema_pkg::RES_BITS-1:0] ema;
  logic                           valid_res;

  modport source (output valid, output sma, output ema, output valid_res, input ready);
  modport sink   (input valid, input sma, input ema, input valid_res, output ready);
endinterface

@@ rtl/core/smema_ring.sv @@
module smema_ring #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // read returns old contents on a same-address write
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/smema_div.sv @@
module smema_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int NST = (NUM_W + 1) / 2;
  localparam int NB  = 2 * NST;
  localparam int CW  = $clog2(NST + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [NB-1:0]    num_r, num_nxt;
  logic [NB-1:0]    quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;

  // two restoring steps per cycle
  always_comb begin
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] rem_t;
    logic [NB-1:0]    num_t;
    logic [NB-1:0]    quo_t;
    rem_t    = rem_r;
    num_t    = num_r;
    quo_t    = quo_r;
    trial    = '0;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_t, num_t[NB-1]};
      num_t = {num_t[NB-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_t = DEN_W'(trial - {1'b0, den_r});
        quo_t = {quo_t[NB-2:0], 1'b1};
      end else begin
        rem_t = trial[DEN_W-1:0];
        quo_t = {quo_t[NB-2:0], 1'b0};
      end
    end
    num_nxt = num_t;
    quo_nxt = quo_t;
    rem_nxt = rem_t;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NST);
      num_nxt  = NB'(num);
      quo_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else begin
      num_nxt = num_r;
      quo_nxt = quo_r;
      rem_nxt = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r[NUM_W-1:0];

endmodule

@@ rtl/core/simple_and_exponential_moving_average.sv @@
// channel | dir | payload                      | handshake
// in_ch   | in  | sample, first_of_series      | valid/ready
// out_ch  | out | sma, ema, valid_res          | valid/ready, output register
// cfg     | in  | window_length @0, alpha @4   | APB, pready tied high
//
// One request at a time. A request with a full window waits on the two-bit-per-cycle
// divider for sum/window; the one that seeds the EMA skips the multiply and update
// states after it. A request before the window fills skips the divider.
// Ring memory is read and written in the same cycle; a read sees the old entry.
// Synchronous active-low reset clears all control and average state, no clearing pass.
// A finished result waits in the output register while the next request is taken.
module simple_and_exponential_moving_average #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  smema_in_if.sink                         in_ch,
  smema_out_if.source                      out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [smema_pkg::CFG_AW-1:0]     paddr,
  input  logic [smema_pkg::CFG_DW-1:0]     pwdata,
  output logic [smema_pkg::CFG_DW-1:0]     prdata,
  output logic                             pready
);

  localparam int AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = SAMPLE_BITS + AW;
  localparam int EMA_W  = SAMPLE_BITS + smema_pkg::EMA_FRAC;
  localparam int LO_W   = EMA_W / 2;
  localparam int HI_W   = EMA_W - LO_W;
  localparam int PROD_W = EMA_W + smema_pkg::ALPHA_W;
  localparam int WIDE_W = SAMPLE_BITS + smema_pkg::RES_BITS;
  localparam int WL_W   = smema_pkg::WL_W;

  smema_pkg::state_t state_r, state_nxt;

  logic [WL_W-1:0]                 wl_r;
  logic [smema_pkg::ALPHA_W-1:0]   alpha_r;
  logic [SAMPLE_BITS-1:0]          x_r;
  logic [CNT_W-1:0]                cnt_r;
  logic [AW-1:0]                   wp_r;
  logic [SUM_W-1:0]                sum_r;
  logic [EMA_W-1:0]                acc_r;
  logic                            started_r;
  logic                            drop_r;
  logic                            vres_r;
  logic [SAMPLE_BITS-1:0]          q_r;
  logic [EMA_W-1:0]                mag_r;
  logic                            neg_r;
  logic [LO_W+smema_pkg::ALPHA_W-1:0] plo_r;
  logic [EMA_W-1:0]                step_r;
  logic                            out_valid_r;
  logic [smema_pkg::RES_BITS-1:0]  out_sma_r;
  logic [smema_pkg::RES_BITS-1:0]  out_ema_r;
  logic                            out_vres_r;

  logic [WL_W-1:0]        w_eff;
  logic                   in_acc;
  logic                   cfg_wr;
  logic                   win_wr;
  logic                   clr;
  logic                   out_load;
  logic                   ring_we;
  logic [AW-1:0]          ring_raddr;
  logic [SAMPLE_BITS-1:0] ring_rdata;
  logic [AW-1:0]          wp_inc;
  logic [SUM_W-1:0]       sum_new;
  logic [CNT_W-1:0]       cnt_new;
  logic                   valid_new;
  logic [SUM_W-1:0]       div_quo;
  logic                   div_start;
  logic                   div_busy;
  logic                   div_done;
  logic [EMA_W-1:0]       target;
  logic [HI_W+smema_pkg::ALPHA_W-1:0] phi;
  logic [PROD_W-1:0]      prod;
  logic [WIDE_W-1:0]      sma_wide;
  logic [WIDE_W-1:0]      ema_wide;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign win_wr = cfg_wr && (smema_pkg::cfg_reg_t'(paddr[2]) == smema_pkg::REG_WINDOW);

  always_comb begin
    case (smema_pkg::cfg_reg_t'(paddr[2]))
      smema_pkg::REG_WINDOW: prdata = smema_pkg::CFG_DW'(wl_r);
      smema_pkg::REG_ALPHA:  prdata = smema_pkg::CFG_DW'(alpha_r);
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    if (wl_r == '0) begin
      w_eff = WL_W'(1);
    end else if (32'(wl_r) > WINDOW_MAX) begin
      w_eff = WL_W'(WINDOW_MAX);
    end else begin
      w_eff = wl_r;
    end
  end

  assign in_ch.ready = (state_r == smema_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign clr         = win_wr || (in_acc && in_ch.first_of_series);

  // oldest sample of a full window
  always_comb begin
    if (32'(wp_r) >= 32'(w_eff)) begin
      ring_raddr = AW'(32'(wp_r) - 32'(w_eff));
    end else begin
      ring_raddr = AW'(32'(wp_r) + WINDOW_MAX - 32'(w_eff));
    end
  end

  assign wp_inc    = (32'(wp_r) + 1 >= WINDOW_MAX) ? '0 : AW'(wp_r + 1'b1);
  assign sum_new   = sum_r - (drop_r ? SUM_W'(ring_rdata) : '0) + SUM_W'(x_r);
  assign cnt_new   = (32'(cnt_r) < WINDOW_MAX) ? CNT_W'(cnt_r + 1'b1) : cnt_r;
  assign valid_new = 32'(cnt_new) >= 32'(w_eff);
  assign target    = {x_r, {smema_pkg::EMA_FRAC{1'b0}}};
  assign phi       = mag_r[EMA_W-1:LO_W] * alpha_r;
  assign prod      = (PROD_W'(phi) << LO_W) + PROD_W'(plo_r)
                   + (neg_r ? PROD_W'(smema_pkg::EMA_BIAS) : '0);

  smema_ring #(
    .DEPTH (WINDOW_MAX),
    .AW    (AW),
    .DW    (SAMPLE_BITS)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp_r),
    .wdata (x_r),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  smema_div #(
    .NUM_W (SUM_W),
    .DEN_W (WL_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_new),
    .den   (w_eff),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smema_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ring_we   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      smema_pkg::S_IDLE: begin
        if (in_acc) state_nxt = smema_pkg::S_RD;
      end
      smema_pkg::S_RD: begin
        ring_we   = 1'b1;
        state_nxt = smema_pkg::S_SUM;
      end
      smema_pkg::S_SUM: begin
        if (valid_new) begin
          div_start = 1'b1;
          state_nxt = smema_pkg::S_DIV;
        end else begin
          state_nxt = smema_pkg::S_OUT;
        end
      end
      smema_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = started_r ? smema_pkg::S_MLO : smema_pkg::S_OUT;
        end
      end
      smema_pkg::S_MLO: state_nxt = smema_pkg::S_MHI;
      smema_pkg::S_MHI: state_nxt = smema_pkg::S_UPD;
      smema_pkg::S_UPD: state_nxt = smema_pkg::S_OUT;
      smema_pkg::S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = smema_pkg::S_IDLE;
        end
      end
      default: state_nxt = smema_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r      <= smema_pkg::WL_RESET;
      alpha_r   <= smema_pkg::ALPHA_RESET;
      cnt_r     <= '0;
      wp_r      <= '0;
      sum_r     <= '0;
      acc_r     <= '0;
      started_r <= 1'b0;
      vres_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (smema_pkg::cfg_reg_t'(paddr[2]))
          smema_pkg::REG_WINDOW: wl_r    <= pwdata[WL_W-1:0];
          smema_pkg::REG_ALPHA:  alpha_r <= pwdata[smema_pkg::ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (clr) begin
        cnt_r     <= '0;
        wp_r      <= '0;
        sum_r     <= '0;
        acc_r     <= '0;
        started_r <= 1'b0;
      end else begin
        case (state_r)
          smema_pkg::S_RD: begin
            wp_r <= wp_inc;
          end
          smema_pkg::S_SUM: begin
            sum_r  <= sum_new;
            cnt_r  <= cnt_new;
            vres_r <= valid_new;
          end
          smema_pkg::S_DIV: begin
            if (div_done && !started_r) begin
              acc_r     <= {div_quo[SAMPLE_BITS-1:0], {smema_pkg::EMA_FRAC{1'b0}}};
              started_r <= 1'b1;
            end
          end
          smema_pkg::S_UPD: begin
            acc_r <= neg_r ? acc_r - step_r : acc_r + step_r;
          end
          default: ;
        endcase
      end
    end
  end

  // datapath holding registers
  always_ff @(posedge clk) begin
    if (in_acc) x_r <= in_ch.sample;
    case (state_r)
      smema_pkg::S_RD:  drop_r <= 32'(cnt_r) >= 32'(w_eff);
      smema_pkg::S_SUM: q_r    <= '0;
      smema_pkg::S_DIV: begin
        if (div_done) begin
          q_r   <= div_quo[SAMPLE_BITS-1:0];
          neg_r <= target < acc_r;
          mag_r <= (target < acc_r) ? acc_r - target : target - acc_r;
        end
      end
      smema_pkg::S_MLO: plo_r  <= mag_r[LO_W-1:0] * alpha_r;
      smema_pkg::S_MHI: step_r <= prod[PROD_W-1:smema_pkg::EMA_FRAC];
      default: ;
    endcase
  end

  assign sma_wide = WIDE_W'(q_r);
  assign ema_wide = vres_r ? WIDE_W'(acc_r[EMA_W-1:smema_pkg::EMA_FRAC]) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_sma_r  <= sma_wide[smema_pkg::RES_BITS-1:0];
      out_ema_r  <= ema_wide[smema_pkg::RES_BITS-1:0];
      out_vres_r <= vres_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.sma       = out_sma_r;
  assign out_ch.ema       = out_ema_r;
  assign out_ch.valid_res = out_vres_r;

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= WINDOW_MAX)
    else $error("sample count above ring depth");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("request taken while previous one in flight");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == smema_pkg::S_DIV))
    else $error("divider finished outside divide state");

endmodule
